[rtl/urbw_pkg.sv]
// ----------------------------------------------------------------------------
// urbw_pkg: shared types and constants
// Buffer depths, derived widths, opcodes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package urbw_pkg;

    localparam int RX_DEPTH = 128;
    localparam int TX_DEPTH = 16;

    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    // wide enough for every count/compare below (depth up to 256, request 8 bits)
    localparam int CALC_W = 10;

    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_FIELD_W = 35;
    localparam int M_DATA_W  = 40;

    localparam logic [OP_W-1:0] OP_LINE_RX   = 3'd0;
    localparam logic [OP_W-1:0] OP_TX_READY  = 3'd1;
    localparam logic [OP_W-1:0] OP_HOST_POP  = 3'd2;
    localparam logic [OP_W-1:0] OP_HOST_PUSH = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_REQ  = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE_REQ = 3'd5;
    localparam logic [OP_W-1:0] OP_FLUSH     = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture item, sample both read ports
        logic exec;   // apply item, load result register
    } urbw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_stall;  // result register full and not being taken
    } urbw_stat_t;

endpackage

[rtl/urbw_ctrl.sv]
// ----------------------------------------------------------------------------
// urbw_ctrl: item sequencer
// Two-state controller: take an item, then apply it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module urbw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  urbw_pkg::urbw_stat_t stat,
    output urbw_pkg::urbw_cmd_t  cmd
);
    import urbw_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!stat.out_stall) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/urbw_dp.sv]
// ----------------------------------------------------------------------------
// urbw_dp: ring buffer datapath
// Both byte stores, their pointers and levels, the wait logic and the
// result register.
// ----------------------------------------------------------------------------
module urbw_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  urbw_pkg::urbw_cmd_t              cmd,
    output urbw_pkg::urbw_stat_t             stat,
    input  logic [urbw_pkg::OP_W-1:0]        s_tuser,
    input  logic [urbw_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [urbw_pkg::M_DATA_W-1:0]    m_tdata
);
    import urbw_pkg::*;

    localparam logic [RX_PTR_W-1:0] RX_PTR_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_PTR_LAST = TX_PTR_W'(TX_DEPTH - 1);
    localparam logic [CALC_W-1:0]   RX_DEPTH_C  = CALC_W'(RX_DEPTH);
    localparam logic [CALC_W-1:0]   TX_DEPTH_C  = CALC_W'(TX_DEPTH);
    localparam logic [CALC_W-1:0]   TX_HALF_C   = CALC_W'(TX_DEPTH / 2);

    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

    // captured item and read-port samples
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] req_reg;
    logic [BYTE_W-1:0] rx_rd_data_reg;
    logic [BYTE_W-1:0] tx_rd_data_reg;

    logic [RX_PTR_W-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RX_PTR_W-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RX_CNT_W-1:0] rx_fill_reg,   rx_fill_next;
    logic [TX_PTR_W-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TX_PTR_W-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [TX_CNT_W-1:0] tx_fill_reg,   tx_fill_next;
    logic [BYTE_W-1:0]   wait_left_reg, wait_left_next;
    logic                writer_wait_reg, writer_wait_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_FIELD_W-1:0] m_fields_reg, m_fields_next;

    logic rx_we;
    logic tx_we;

    logic                tx_valid, rd_valid, push_ok, dropped, wake_r, wake_w;
    logic [BYTE_W-1:0]   tx_byte, rd_byte;
    logic [CALC_W-1:0]   rx_fill_c, tx_fill_c, tx_fill_after, req_c, n_c, room_c, short_c;
    logic [CALC_W-1:0]   rx_lvl_c, tx_lvl_c;

    assign stat.out_stall = m_valid_reg && !m_tready;
    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = {{(M_DATA_W - M_FIELD_W){1'b0}}, m_fields_reg};

    always_comb begin
        rx_wr_ptr_next   = rx_wr_ptr_reg;
        rx_rd_ptr_next   = rx_rd_ptr_reg;
        rx_fill_next     = rx_fill_reg;
        tx_wr_ptr_next   = tx_wr_ptr_reg;
        tx_rd_ptr_next   = tx_rd_ptr_reg;
        tx_fill_next     = tx_fill_reg;
        wait_left_next   = wait_left_reg;
        writer_wait_next = writer_wait_reg;
        rx_we    = 1'b0;
        tx_we    = 1'b0;
        tx_valid = 1'b0;
        tx_byte  = '0;
        rd_valid = 1'b0;
        rd_byte  = '0;
        push_ok  = 1'b0;
        dropped  = 1'b0;
        wake_r   = 1'b0;
        wake_w   = 1'b0;

        rx_fill_c     = CALC_W'(rx_fill_reg);
        tx_fill_c     = CALC_W'(tx_fill_reg);
        req_c         = CALC_W'(req_reg);
        n_c           = (req_c > RX_DEPTH_C) ? RX_DEPTH_C : req_c;
        short_c       = n_c - rx_fill_c;
        room_c        = TX_DEPTH_C - tx_fill_c;
        tx_fill_after = tx_fill_c;

        case (op_reg)
            OP_LINE_RX: begin
                if (rx_fill_c < RX_DEPTH_C) begin
                    rx_we          = 1'b1;
                    rx_wr_ptr_next = (rx_wr_ptr_reg == RX_PTR_LAST) ? '0
                                     : rx_wr_ptr_reg + 1'b1;
                    rx_fill_next   = rx_fill_reg + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
                if (wait_left_reg != '0) begin
                    wait_left_next = wait_left_reg - 1'b1;
                    wake_r         = (wait_left_reg == BYTE_W'(1));
                end
            end
            OP_TX_READY: begin
                if (tx_fill_reg != '0) begin
                    tx_valid       = 1'b1;
                    tx_byte        = tx_rd_data_reg;
                    tx_rd_ptr_next = (tx_rd_ptr_reg == TX_PTR_LAST) ? '0
                                     : tx_rd_ptr_reg + 1'b1;
                    tx_fill_next   = tx_fill_reg - 1'b1;
                    tx_fill_after  = tx_fill_c - 1'b1;
                end
                if ((tx_fill_after < TX_HALF_C) && writer_wait_reg) begin
                    writer_wait_next = 1'b0;
                    wake_w           = 1'b1;
                end
            end
            OP_HOST_POP: begin
                if (rx_fill_reg != '0) begin
                    rd_valid       = 1'b1;
                    rd_byte        = rx_rd_data_reg;
                    rx_rd_ptr_next = (rx_rd_ptr_reg == RX_PTR_LAST) ? '0
                                     : rx_rd_ptr_reg + 1'b1;
                    rx_fill_next   = rx_fill_reg - 1'b1;
                end
            end
            OP_HOST_PUSH: begin
                if (tx_fill_c < TX_DEPTH_C) begin
                    tx_we          = 1'b1;
                    tx_wr_ptr_next = (tx_wr_ptr_reg == TX_PTR_LAST) ? '0
                                     : tx_wr_ptr_reg + 1'b1;
                    tx_fill_next   = tx_fill_reg + 1'b1;
                    push_ok        = 1'b1;
                end
            end
            OP_READ_REQ: begin
                if (rx_fill_c < n_c) begin
                    wait_left_next = short_c[BYTE_W-1:0];
                end
            end
            OP_WRITE_REQ: begin
                if ((room_c < req_c) && (room_c < TX_HALF_C)) begin
                    writer_wait_next = 1'b1;
                end
            end
            OP_FLUSH: begin
                rx_wr_ptr_next   = '0;
                rx_rd_ptr_next   = '0;
                rx_fill_next     = '0;
                tx_wr_ptr_next   = '0;
                tx_rd_ptr_next   = '0;
                tx_fill_next     = '0;
                wait_left_next   = '0;
                writer_wait_next = 1'b0;
            end
            default: begin
            end
        endcase

        // levels after this step, masked to the field widths
        rx_lvl_c = CALC_W'(rx_fill_next);
        tx_lvl_c = CALC_W'(tx_fill_next);

        m_fields_next = {tx_lvl_c[4:0], rx_lvl_c[7:0], wake_w, wake_r, dropped,
                         push_ok, rd_byte, rd_valid, tx_byte, tx_valid};

        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // stores: write on apply, read ports sampled when the item is taken
    always_ff @(posedge aclk) begin
        if (cmd.exec && rx_we) begin
            rx_mem[rx_wr_ptr_reg] <= byte_reg;
        end
        if (cmd.exec && tx_we) begin
            tx_mem[tx_wr_ptr_reg] <= byte_reg;
        end
        if (cmd.load) begin
            rx_rd_data_reg <= rx_mem[rx_rd_ptr_reg];
            tx_rd_data_reg <= tx_mem[tx_rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata[7:0];
            req_reg  <= s_tdata[15:8];
        end
        if (cmd.exec) begin
            m_fields_reg <= m_fields_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_ptr_reg   <= '0;
            rx_rd_ptr_reg   <= '0;
            rx_fill_reg     <= '0;
            tx_wr_ptr_reg   <= '0;
            tx_rd_ptr_reg   <= '0;
            tx_fill_reg     <= '0;
            wait_left_reg   <= '0;
            writer_wait_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.exec) begin
                rx_wr_ptr_reg   <= rx_wr_ptr_next;
                rx_rd_ptr_reg   <= rx_rd_ptr_next;
                rx_fill_reg     <= rx_fill_next;
                tx_wr_ptr_reg   <= tx_wr_ptr_next;
                tx_rd_ptr_reg   <= tx_rd_ptr_next;
                tx_fill_reg     <= tx_fill_next;
                wait_left_reg   <= wait_left_next;
                writer_wait_reg <= writer_wait_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/uart_ring_buffers_with_wake.sv]
// ----------------------------------------------------------------------------
// uart_ring_buffers_with_wake: serial port receive/transmit ring buffers
// One command stream drives a 128-byte receive ring and a 16-byte transmit
// ring, with reader and writer wake flags.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel: one command per item. s_tuser carries the opcode (line rx
//   byte, tx ready, host pop, host push, read request, write request, flush);
//   s_tdata carries the byte and the request count.
//   Master channel: exactly one result item per command, in command order,
//   with the popped bytes, status flags, wake flags and both ring levels.
// Timing
//   An item is taken in the idle state and applied in the exec state once the
//   result register can take the outcome; m_tvalid rises as it is applied.
//   No new item is taken until the last is applied, set by the take/apply
//   sequence of the controller: each read port is sampled as an item is
//   taken, the store and the pointers are updated as it is applied.
// Reset
//   aresetn low empties both rings, clears the read wait and writer wait,
//   and drops any pending result. Store contents are left as they are.
// Back-pressure
//   A result waits in the output register while m_tready is low; the next
//   command is still taken, but is not applied until that result leaves.
// ----------------------------------------------------------------------------
module uart_ring_buffers_with_wake (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] byte_in, [15:8] request_count
    input  logic [urbw_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] opcode
    input  logic [urbw_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] rd_valid, [17:10] rd_byte,
    // [18] push_accepted, [19] rx_dropped, [20] wake_reader, [21] wake_writer,
    // [29:22] rx_level, [34:30] tx_level, [39:35] zero
    output logic [urbw_pkg::M_DATA_W-1:0] m_tdata
);
    import urbw_pkg::*;

    urbw_cmd_t  cmd;
    urbw_stat_t stat;

    // sequencer: take / apply
    urbw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // rings, wait logic and result register
    urbw_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[dv/uart_ring_buffers_with_wake_test.sv]
// ----------------------------------------------------------------------------
// uart_ring_buffers_with_wake_test: self-checking bench for the UART rings
// Drives opcode items into the slave channel and checks every result item
// against a cycle-free model of both rings and the reader/writer wake logic
// held in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
module uart_ring_buffers_with_wake_test;
    import urbw_pkg::*;

    // opcode 7 has no package name; the block treats it as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    // result item, MSB first so that a cast of m_tdata lines up
    typedef struct packed {
        logic [4:0] pad;
        logic [4:0] tx_level;
        logic [7:0] rx_level;
        logic       wake_writer;
        logic       wake_reader;
        logic       rx_dropped;
        logic       push_accepted;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } port_status_t;

    typedef enum {FILL_RX, DRAIN_RX, FILL_TX, DRAIN_TX, WAIT_RX, MIXED} burst_kind_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [7:0] byte_in, [15:8] request_count
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    // [2:0] opcode
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] tx_valid, [8:1] tx_byte, [9] rd_valid, [17:10] rd_byte,
    // [18] push_accepted, [19] rx_dropped, [20] wake_reader, [21] wake_writer,
    // [29:22] rx_level, [34:30] tx_level, [39:35] zero
    logic [M_DATA_W-1:0]   m_tdata;

    uart_ring_buffers_with_wake u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Ring model: its own copy of both rings and the wait state
    // ------------------------------------------------------------------
    logic [7:0]  rx_ring [RX_DEPTH];
    logic [7:0]  tx_ring [TX_DEPTH];
    int unsigned rx_head, rx_tail, rx_count;
    int unsigned tx_head, tx_tail, tx_count;
    int unsigned reads_owed;
    bit          writer_parked;

    port_status_t awaited_status[$];

    int  items_sent;
    int  results_seen;
    int  mismatches;
    int  cycle_count;
    int  drops_seen, reader_wakes, writer_wakes, refused_pushes;
    int  sink_hold;
    bit  calm;          // no idling on either side while set

    function automatic void clear_rings();
        rx_head = 0; rx_tail = 0; rx_count = 0;
        tx_head = 0; tx_tail = 0; tx_count = 0;
        reads_owed = 0;
        writer_parked = 1'b0;
    endfunction

    // applies one command to the model, returns the status item it produces
    function automatic port_status_t apply_uart_op(logic [OP_W-1:0] op,
                                                   logic [7:0] data_byte,
                                                   logic [7:0] count);
        port_status_t r;
        int unsigned  wanted;
        int unsigned  room;
        r = '0;
        case (op)
            OP_LINE_RX: begin
                if (rx_count < RX_DEPTH) begin
                    rx_ring[rx_head[RX_PTR_W-1:0]] = data_byte;
                    rx_head = (rx_head + 1) % RX_DEPTH;
                    rx_count++;
                end else begin
                    r.rx_dropped = 1'b1;
                    drops_seen++;
                end
                // countdown runs on dropped bytes too
                if (reads_owed > 0) begin
                    reads_owed--;
                    if (reads_owed == 0) begin
                        r.wake_reader = 1'b1;
                        reader_wakes++;
                    end
                end
            end
            OP_TX_READY: begin
                if (tx_count > 0) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = tx_ring[tx_tail[TX_PTR_W-1:0]];
                    tx_tail = (tx_tail + 1) % TX_DEPTH;
                    tx_count--;
                end
                if (tx_count < TX_DEPTH / 2 && writer_parked) begin
                    writer_parked = 1'b0;
                    r.wake_writer = 1'b1;
                    writer_wakes++;
                end
            end
            OP_HOST_POP: begin
                if (rx_count > 0) begin
                    r.rd_valid = 1'b1;
                    r.rd_byte  = rx_ring[rx_tail[RX_PTR_W-1:0]];
                    rx_tail = (rx_tail + 1) % RX_DEPTH;
                    rx_count--;
                end
            end
            OP_HOST_PUSH: begin
                if (tx_count < TX_DEPTH) begin
                    tx_ring[tx_head[TX_PTR_W-1:0]] = data_byte;
                    tx_head = (tx_head + 1) % TX_DEPTH;
                    tx_count++;
                    r.push_accepted = 1'b1;
                end else begin
                    refused_pushes++;
                end
            end
            OP_READ_REQ: begin
                wanted = (32'(count) > RX_DEPTH) ? RX_DEPTH : 32'(count);
                if (rx_count < wanted)
                    reads_owed = (wanted - rx_count) & 8'hFF;
            end
            OP_WRITE_REQ: begin
                room = TX_DEPTH - tx_count;
                if (room < 32'(count) && room < TX_DEPTH / 2)
                    writer_parked = 1'b1;
            end
            OP_FLUSH: clear_rings();
            default: ;
        endcase
        r.rx_level = rx_count[7:0];
        r.tx_level = tx_count[4:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // One item on the slave channel. tvalid is only dropped when a gap is
    // drawn, so back-to-back items never see a lower/raise in one step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] data_byte,
                             input logic [7:0] count);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {count, data_byte};
        do @(posedge aclk); while (!s_tready);
        awaited_status.push_back(apply_uart_op(op, data_byte, count));
        items_sent++;
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_status.size() != 0) @(posedge aclk);
    endtask

    // field extremes, every opcode, wait arming and the flush clearing it
    task automatic test_basic_ops();
        send_item(OP_FLUSH,     8'h00, 8'h00);
        send_item(OP_UNUSED,    8'hFF, 8'hFF);
        send_item(OP_LINE_RX,   8'h00, 8'h00);
        send_item(OP_LINE_RX,   8'hFF, 8'hFF);
        send_item(OP_READ_REQ,  8'h00, 8'h00);   // enough held, wait untouched
        send_item(OP_READ_REQ,  8'h00, 8'd4);    // shortfall of two
        send_item(OP_LINE_RX,   8'h5A, 8'h00);
        send_item(OP_LINE_RX,   8'hA5, 8'h00);   // reader wakes here
        repeat (4) send_item(OP_HOST_POP, 8'h00, 8'h00);
        send_item(OP_HOST_POP,  8'h00, 8'h00);   // empty receive ring
        send_item(OP_HOST_PUSH, 8'h00, 8'h00);
        send_item(OP_HOST_PUSH, 8'hFF, 8'h00);
        send_item(OP_TX_READY,  8'h00, 8'h00);
        send_item(OP_TX_READY,  8'h00, 8'h00);
        send_item(OP_TX_READY,  8'h00, 8'h00);   // empty transmit ring
        send_item(OP_WRITE_REQ, 8'h00, 8'hFF);   // plenty of room, no wait
        send_item(OP_WRITE_REQ, 8'h00, 8'h00);
        send_item(OP_READ_REQ,  8'h00, 8'hFF);   // clamps to receive depth
        send_item(OP_LINE_RX,   8'h3C, 8'h00);
        send_item(OP_FLUSH,     8'h00, 8'h00);   // wait count cleared too
        send_item(OP_LINE_RX,   8'hC3, 8'h00);   // so no wake here
        send_item(OP_HOST_POP,  8'h00, 8'h00);
    endtask

    // fill the receive ring past full with a read wait pending, then drain
    task automatic test_rx_overflow();
        send_item(OP_FLUSH, 8'h00, 8'h00);
        send_item(OP_READ_REQ, 8'h00, 8'd200);
        repeat (RX_DEPTH + 2) send_item(OP_LINE_RX, 8'($urandom_range(0, 255)), 8'h00);
        send_item(OP_READ_REQ, 8'h00, 8'hFF);    // ring full, nothing owed
        repeat (RX_DEPTH + 1) send_item(OP_HOST_POP, 8'h00, 8'h00);
        wait_for_results();
    endtask

    // fill the transmit ring, refuse a push, park the writer, release it
    task automatic test_tx_backlog();
        send_item(OP_FLUSH, 8'h00, 8'h00);
        repeat (TX_DEPTH + 1) send_item(OP_HOST_PUSH, 8'($urandom_range(0, 255)), 8'h00);
        send_item(OP_WRITE_REQ, 8'h00, 8'hFF);
        repeat (TX_DEPTH + 1) send_item(OP_TX_READY, 8'h00, 8'h00);
        repeat (6) send_item(OP_HOST_PUSH, 8'($urandom_range(0, 255)), 8'h00);
        send_item(OP_WRITE_REQ, 8'h00, 8'd3);    // room 10: not short
        repeat (6) send_item(OP_TX_READY, 8'h00, 8'h00);
    endtask

    // bursts that lean toward filling or draining one ring, with noise mixed in
    task automatic test_random_traffic(input int target);
        burst_kind_t kind;
        int          len;
        int          roll;
        int          first;
        logic [OP_W-1:0] op;
        logic [7:0]  count;
        first = items_sent;
        calm  = 1'b1;
        while (items_sent - first < target) begin
            if (items_sent - first >= 150)
                calm = 1'b0;
            kind = burst_kind_t'($urandom_range(0, 5));
            len  = $urandom_range(4, 48);
            repeat (len) begin
                roll = $urandom_range(0, 99);
                case (kind)
                    FILL_RX:  op = (roll < 75) ? OP_LINE_RX :
                                   (roll < 90) ? OP_HOST_POP : OP_READ_REQ;
                    DRAIN_RX: op = (roll < 70) ? OP_HOST_POP :
                                   (roll < 90) ? OP_LINE_RX : OP_READ_REQ;
                    FILL_TX:  op = (roll < 70) ? OP_HOST_PUSH :
                                   (roll < 85) ? OP_TX_READY : OP_WRITE_REQ;
                    DRAIN_TX: op = (roll < 70) ? OP_TX_READY :
                                   (roll < 85) ? OP_HOST_PUSH : OP_WRITE_REQ;
                    WAIT_RX:  op = (roll < 10) ? OP_READ_REQ :
                                   (roll < 80) ? OP_LINE_RX : OP_HOST_POP;
                    default: begin
                        // flush kept rare so the rings get a chance to fill
                        op = OP_W'($urandom_range(0, 6));
                        if (op == OP_FLUSH)
                            op = OP_UNUSED;
                        if (roll < 3)
                            op = OP_FLUSH;
                    end
                endcase
                // small counts hit the interesting thresholds more often
                count = 8'($urandom_range(0, 1) ? $urandom_range(0, 24)
                                                : $urandom_range(0, 255));
                send_item(op, 8'($urandom_range(0, 255)), count);
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall on m_tready, check each accepted item
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        port_status_t got;
        port_status_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = port_status_t'(m_tdata);
                results_seen++;
                if (awaited_status.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with none expected, actual 0x%0h",
                             $time, m_tdata);
                end else begin
                    want = awaited_status.pop_front();
                    compare_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
                    compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
                    compare_field("rd_valid", 32'(want.rd_valid), 32'(got.rd_valid));
                    compare_field("rd_byte", 32'(want.rd_byte), 32'(got.rd_byte));
                    compare_field("push_accepted", 32'(want.push_accepted),
                                  32'(got.push_accepted));
                    compare_field("rx_dropped", 32'(want.rx_dropped), 32'(got.rx_dropped));
                    compare_field("wake_reader", 32'(want.wake_reader),
                                  32'(got.wake_reader));
                    compare_field("wake_writer", 32'(want.wake_writer),
                                  32'(got.wake_writer));
                    compare_field("rx_level", 32'(want.rx_level), 32'(got.rx_level));
                    compare_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
                    compare_field("pad", 32'(want.pad), 32'(got.pad));
                end
                sink_hold = calm ? 0 : $urandom_range(0, 4);
            end else if (sink_hold > 0) begin
                sink_hold--;
            end
            m_tready <= (sink_hold == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     awaited_status.size());
            $display("uart_ring_buffers_with_wake verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clear_rings();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_rx_overflow();
        test_tx_backlog();
        test_random_traffic(900);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items, checked %0d results, %0d mismatches.",
                 items_sent, results_seen, mismatches);
        $display("Saw %0d rx drops, %0d refused pushes, %0d reader and %0d writer wakes.",
                 drops_seen, refused_pushes, reader_wakes, writer_wakes);
        if (mismatches == 0 && awaited_status.size() == 0) begin
            $display("uart_ring_buffers_with_wake verification clean");
        end else begin
            $display("uart_ring_buffers_with_wake verification failed");
        end
        $finish;
    end

endmodule
